### rtl/core/fpsc_pkg.sv
// ----------------------------------------------------------------------------
// fpsc_pkg
// shared widths, constants and control types of the filtered pi speed controller
// ----------------------------------------------------------------------------
`default_nettype none

package fpsc_pkg;

  // field widths
  localparam int unsigned SpeedW   = 16;  // q8.8
  localparam int unsigned DtW      = 20;  // q0.20
  localparam int unsigned GainW    = 16;  // q8.8
  localparam int unsigned FiltW    = 24;  // q8.16
  localparam int unsigned ErrW     = 25;  // signed q.16
  localparam int unsigned IntegW   = 32;  // signed q16.16
  localparam int unsigned DriveW   = 8;
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 16;

  // shared multiply-accumulate unit
  localparam int unsigned MulXW = 33;
  localparam int unsigned MulYW = 21;
  localparam int unsigned AccW  = MulXW + MulYW;

  // filter taps in q0.16
  localparam logic [15:0] CoefA = 16'd55968;
  localparam logic [15:0] CoefB = 16'd4771;

  // register reset values
  localparam logic [GainW-1:0] SetpointRst = 16'd25600;
  localparam logic [GainW-1:0] PGainRst    = 16'd1024;
  localparam logic [GainW-1:0] IGainRst    = 16'd12800;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SETPOINT = 8'd0,
    REG_P_GAIN   = 8'd1,
    REG_I_GAIN   = 8'd2
  } cfg_reg_e;

  typedef enum logic [2:0] {
    OP_NONE  = 3'd0,
    OP_FILT  = 3'd1,  // coef a times filtered speed
    OP_TAPS  = 3'd2,  // coef b times speed sum
    OP_ERRDT = 3'd3,  // error magnitude times time step
    OP_PROP  = 3'd4,  // p gain times error
    OP_INTEG = 3'd5   // i gain times integral
  } op_sel_e;

  typedef struct packed {
    logic    mac_en;
    logic    mac_acc;
    op_sel_e op_sel;
    logic    ld_filt;
    logic    ld_integ;
    logic    ld_out;
    logic    in_ready;
  } fpsc_ctrl_t;

endpackage

`default_nettype wire

### rtl/core/fpsc_if.sv
// ----------------------------------------------------------------------------
// fpsc_if
// valid/ready channels of the filtered pi speed controller
// ----------------------------------------------------------------------------
`default_nettype none

interface fpsc_in_if import fpsc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [SpeedW-1:0] measured_speed;
  logic [DtW-1:0]    time_step;

  modport source (output valid, output measured_speed, output time_step, input ready);
  modport sink   (input valid, input measured_speed, input time_step, output ready);
endinterface

interface fpsc_out_if import fpsc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DriveW-1:0] drive_level;
  logic              drive_saturated;
  logic              demand_negative;

  modport source (output valid, output drive_level, output drive_saturated,
                  output demand_negative, input ready);
  modport sink   (input valid, input drive_level, input drive_saturated,
                  input demand_negative, output ready);
endinterface

interface fpsc_cfg_if import fpsc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### rtl/core/fpsc_mac.sv
// ----------------------------------------------------------------------------
// fpsc_mac
// shared signed multiplier with a registered accumulator
// ----------------------------------------------------------------------------
`default_nettype none

module fpsc_mac import fpsc_pkg::*; (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    en_i,
  input  wire logic                    acc_i,   // add to the running value
  input  wire logic signed [MulXW-1:0] x_i,
  input  wire logic signed [MulYW-1:0] y_i,
  output      logic signed [AccW-1:0]  acc_o
);

  logic signed [AccW-1:0] prod;
  logic signed [AccW-1:0] acc_d, acc_q;

  assign prod  = x_i * y_i;
  assign acc_d = (acc_i ? acc_q : '0) + prod;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (en_i) begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule

`default_nettype wire

### rtl/core/fpsc_ctrl.sv
// ----------------------------------------------------------------------------
// fpsc_ctrl
// sequencer that steps one sample through the shared multiply-accumulate unit
// ----------------------------------------------------------------------------
`default_nettype none

module fpsc_ctrl import fpsc_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  input  wire logic out_free_i,
  output fpsc_ctrl_t ctrl_o
);

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_MUL_A = 9'b000000010,
    ST_MUL_B = 9'b000000100,
    ST_FILT  = 9'b000001000,
    ST_MUL_E = 9'b000010000,
    ST_INTEG = 9'b000100000,
    ST_MUL_P = 9'b001000000,
    ST_MUL_I = 9'b010000000,
    ST_DONE  = 9'b100000000
  } state_e;

  state_e state_d, state_q;

  always_comb begin
    state_d = state_q;
    ctrl_o  = '{mac_en: 1'b0, mac_acc: 1'b0, op_sel: OP_NONE, ld_filt: 1'b0,
                ld_integ: 1'b0, ld_out: 1'b0, in_ready: 1'b0};
    unique case (state_q)
      ST_IDLE: begin
        ctrl_o.in_ready = 1'b1;
        if (in_valid_i) state_d = ST_MUL_A;
      end
      ST_MUL_A: begin
        ctrl_o.mac_en = 1'b1;
        ctrl_o.op_sel = OP_FILT;
        state_d       = ST_MUL_B;
      end
      ST_MUL_B: begin
        ctrl_o.mac_en  = 1'b1;
        ctrl_o.mac_acc = 1'b1;
        ctrl_o.op_sel  = OP_TAPS;
        state_d        = ST_FILT;
      end
      ST_FILT: begin
        ctrl_o.ld_filt = 1'b1;
        state_d        = ST_MUL_E;
      end
      ST_MUL_E: begin
        ctrl_o.mac_en = 1'b1;
        ctrl_o.op_sel = OP_ERRDT;
        state_d       = ST_INTEG;
      end
      ST_INTEG: begin
        ctrl_o.ld_integ = 1'b1;
        state_d         = ST_MUL_P;
      end
      ST_MUL_P: begin
        ctrl_o.mac_en = 1'b1;
        ctrl_o.op_sel = OP_PROP;
        state_d       = ST_MUL_I;
      end
      ST_MUL_I: begin
        ctrl_o.mac_en  = 1'b1;
        ctrl_o.mac_acc = 1'b1;
        ctrl_o.op_sel  = OP_INTEG;
        state_d        = ST_DONE;
      end
      ST_DONE: begin
        if (out_free_i) begin
          ctrl_o.ld_out = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

### rtl/core/filtered_pi_speed_controller_top.sv
// ----------------------------------------------------------------------------
// filtered_pi_speed_controller_top
// low-pass filtered pi speed loop with saturating integral and 8-bit drive
// ----------------------------------------------------------------------------
//
//   channel  dir  handshake      payload
//   -------  ---  -------------  ------------------------------------------
//   in_i     in   valid / ready  measured_speed[15:0], time_step[19:0]
//   out_o    out  valid / ready  drive_level[7:0], drive_saturated,
//                                demand_negative
//   cfg_i    in   valid / ready  index[7:0], data[15:0] (0 setpoint,
//                                1 p gain, 2 i gain, others ignored)
//
// after acceptance the shared 33x21 multiplier is used five times under the
// sequencer, with a rounding step after the filter and after the integral
// product, before the result is loaded into the output register.
// in_i is ready only while the sequencer is idle; a finished result sits in
// the output register so the next request is taken while it waits.
// if the output register is still full, the sequencer holds in its last step.
// reset clears filter, previous speed and integral and reloads the registers.
// cfg_i is always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module filtered_pi_speed_controller_top import fpsc_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  fpsc_in_if.sink   in_i,
  fpsc_out_if.source out_o,
  fpsc_cfg_if.sink  cfg_i
);

  // control from the sequencer
  fpsc_ctrl_t ctrl;
  logic       in_acc;
  logic       out_free;

  // configuration registers
  logic [GainW-1:0] setpoint_q, p_gain_q, i_gain_q;

  // sample latched at acceptance
  logic [SpeedW-1:0] speed_q;
  logic [DtW-1:0]    dt_q;

  // loop state
  logic [FiltW-1:0]         filt_q;
  logic [SpeedW-1:0]        prev_q;
  logic signed [ErrW-1:0]   err_q;
  logic signed [IntegW-1:0] integ_q;

  // output register
  logic              out_valid_q;
  logic [DriveW-1:0] drive_q;
  logic              sat_q, neg_q;

  // shared multiplier operands and accumulator
  logic signed [MulXW-1:0] mul_x;
  logic signed [MulYW-1:0] mul_y;
  logic signed [AccW-1:0]  acc;

  assign in_acc   = in_i.valid & ctrl.in_ready;
  assign out_free = ~out_valid_q | out_o.ready;

  fpsc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .out_free_i (out_free),
    .ctrl_o     (ctrl)
  );

  // ---------------------------------------------------------------------------
  // configuration writes
  // ---------------------------------------------------------------------------
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      setpoint_q <= SetpointRst;
      p_gain_q   <= PGainRst;
      i_gain_q   <= IGainRst;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_SETPOINT: setpoint_q <= cfg_i.data;
        REG_P_GAIN:   p_gain_q   <= cfg_i.data;
        REG_I_GAIN:   i_gain_q   <= cfg_i.data;
        default: ;  // unknown index, write dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // operand selection for the shared multiplier
  // ---------------------------------------------------------------------------
  logic [SpeedW:0]   tap_sum;   // speed + previous speed
  logic [ErrW-1:0]   err_mag;   // |error|, below 2^24

  assign tap_sum = {1'b0, speed_q} + {1'b0, prev_q};
  assign err_mag = err_q[ErrW-1] ? ErrW'(-err_q) : ErrW'(err_q);

  always_comb begin
    mul_x = '0;
    mul_y = '0;
    case (ctrl.op_sel)
      OP_FILT: begin
        mul_x = $signed({(MulXW-FiltW)'(0), filt_q});
        mul_y = $signed({(MulYW-16)'(0), CoefA});
      end
      OP_TAPS: begin
        // b * (speed + previous) lifted from q8.24 to q8.32
        mul_x = $signed({(MulXW-SpeedW-9)'(0), tap_sum, 8'd0});
        mul_y = $signed({(MulYW-16)'(0), CoefB});
      end
      OP_ERRDT: begin
        mul_x = $signed({(MulXW-ErrW)'(0), err_mag});
        mul_y = $signed({(MulYW-DtW)'(0), dt_q});
      end
      OP_PROP: begin
        mul_x = {{(MulXW-ErrW){err_q[ErrW-1]}}, err_q};
        mul_y = $signed({(MulYW-GainW)'(0), p_gain_q});
      end
      OP_INTEG: begin
        mul_x = {{(MulXW-IntegW){integ_q[IntegW-1]}}, integ_q};
        mul_y = $signed({(MulYW-GainW)'(0), i_gain_q});
      end
      default: ;
    endcase
  end

  fpsc_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (ctrl.mac_en),
    .acc_i  (ctrl.mac_acc),
    .x_i    (mul_x),
    .y_i    (mul_y),
    .acc_o  (acc)
  );

  // ---------------------------------------------------------------------------
  // filter rounding: q8.32 sum rounded half up to q8.16, clamped to 24 bits
  // ---------------------------------------------------------------------------
  logic [41:0]           filt_rnd;
  logic [FiltW-1:0]      filt_d;
  logic signed [ErrW-1:0] err_d;

  assign filt_rnd = {1'b0, acc[40:0]} + 42'h8000;
  assign filt_d   = (|filt_rnd[41:40]) ? {FiltW{1'b1}} : filt_rnd[39:16];
  // error in q.16 against the freshly filtered speed
  assign err_d    = $signed({1'b0, setpoint_q, 8'd0}) - $signed({1'b0, filt_d});

  // ---------------------------------------------------------------------------
  // integral step: e*dt in q.36 rounded half away from zero, saturating add
  // ---------------------------------------------------------------------------
  logic [44:0]              prod_rnd;
  logic [24:0]              step_mag;
  logic signed [IntegW+1:0] step_s;
  logic signed [IntegW+1:0] integ_sum;
  logic signed [IntegW-1:0] integ_d;

  assign prod_rnd  = {1'b0, acc[43:0]} + 45'h80000;
  assign step_mag  = prod_rnd[44:20];
  // product sign follows the error (dt is never negative; zero rounds to zero)
  assign step_s    = err_q[ErrW-1] ? -$signed({(IntegW+2-25)'(0), step_mag})
                                   :  $signed({(IntegW+2-25)'(0), step_mag});
  assign integ_sum = {{2{integ_q[IntegW-1]}}, integ_q} + step_s;

  always_comb begin
    if (integ_sum > $signed({2'b00, 1'b0, {(IntegW-1){1'b1}}})) begin
      integ_d = {1'b0, {(IntegW-1){1'b1}}};
    end else if (integ_sum < $signed({2'b11, 1'b1, {(IntegW-1){1'b0}}})) begin
      integ_d = {1'b1, {(IntegW-1){1'b0}}};
    end else begin
      integ_d = integ_sum[IntegW-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // drive: integer part of |u| in q.24, clipped at full scale
  // ---------------------------------------------------------------------------
  logic            u_neg;
  logic [AccW-1:0] u_mag;
  logic [AccW-25:0] u_int;
  logic            u_sat;

  assign u_neg = acc[AccW-1];
  assign u_mag = u_neg ? AccW'(-acc) : AccW'(acc);
  assign u_int = u_mag[AccW-1:24];
  assign u_sat = |u_int[AccW-25:DriveW];

  // ---------------------------------------------------------------------------
  // state registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      speed_q <= in_i.measured_speed;
      dt_q    <= in_i.time_step;
    end
    if (ctrl.ld_filt) err_q <= err_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filt_q  <= '0;
      prev_q  <= '0;
      integ_q <= '0;
    end else begin
      if (ctrl.ld_filt) begin
        filt_q <= filt_d;
        prev_q <= speed_q;
      end
      if (ctrl.ld_integ) integ_q <= integ_d;
    end
  end

  // output register, refilled only once the previous result has gone
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.ld_out) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.ld_out) begin
      drive_q <= u_sat ? {DriveW{1'b1}} : u_int[DriveW-1:0];
      sat_q   <= u_sat;
      neg_q   <= u_neg;
    end
  end

  assign in_i.ready            = ctrl.in_ready;
  assign out_o.valid           = out_valid_q;
  assign out_o.drive_level     = drive_q;
  assign out_o.drive_saturated = sat_q;
  assign out_o.demand_negative = neg_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  // an accepted request keeps the input closed while it is worked on
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !ctrl.in_ready)
    else $error("input ready right after a request was accepted");

  // a result is loaded only into a free output register
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.ld_out |-> (!out_valid_q || out_o.ready))
    else $error("result loaded over an untaken result");

  // the filter product starts the cycle after acceptance
  a_seq_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (ctrl.mac_en && !ctrl.mac_acc && ctrl.op_sel == OP_FILT))
    else $error("sequencer did not start the filter after acceptance");

  // output valid only rises from a load by the sequencer
  a_valid_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(ctrl.ld_out))
    else $error("output valid rose without a result load");

endmodule

`default_nettype wire

### test/tb_filtered_pi_speed_controller_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_filtered_pi_speed_controller_top
// self-checking bench for the filtered pi speed controller: a short table of
// hand-picked speed requests, then random request streams under several gain
// and setpoint settings and handshake idling mixes, every drive result
// compared against a typed-in drive or an in-bench model of the filter, integral and pi sum
// ----------------------------------------------------------------------------

module tb_filtered_pi_speed_controller_top;
  import fpsc_pkg::*;

  // drive result as seen on out_o
  typedef struct packed {
    logic [DriveW-1:0] level;
    logic              sat;
    logic              neg;
  } drive_t;

  // one row of the hand-written request table
  typedef struct {
    logic [SpeedW-1:0] speed;
    logic [DtW-1:0]    dt;
    bit                known;   // drive below is typed in, not predicted
    drive_t            drive;
  } speed_vec_t;

  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_e;

  typedef enum int {
    STIM_TRACK,    // speed hovering near the setpoint, short time steps
    STIM_EXTREME,  // speed pinned far from the setpoint, long time steps
    STIM_NOISE     // anything the fields allow
  } stim_style_e;

  localparam int          QuietLimit   = 2000;
  localparam int          DrainCycles  = 20;
  localparam int          MaxPrints    = 30;
  localparam int          NumPhases    = 12;
  localparam int          PhaseItems   = 100;
  localparam int          SatPhaseItems = 200;
  localparam longint      IntegMax     = 64'sd2147483647;
  localparam longint      IntegMin     = -IntegMax - 1;
  localparam logic [CfgIdxW-1:0] FirstUnusedIdx = REG_I_GAIN + 1;

  logic clk_i;
  logic rst_ni;

  fpsc_in_if  in_ch ();
  fpsc_out_if out_ch ();
  fpsc_cfg_if cfg_ch ();

  filtered_pi_speed_controller_top u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  // --------------------------------------------------------------------------
  // model state: register copies plus filter, previous speed and integral
  // --------------------------------------------------------------------------
  logic [GainW-1:0]         setpoint_q = SetpointRst;
  logic [GainW-1:0]         p_gain_q   = PGainRst;
  logic [GainW-1:0]         i_gain_q   = IGainRst;
  logic [FiltW-1:0]         filt_q     = '0;
  logic [SpeedW-1:0]        prev_q     = '0;
  logic signed [IntegW-1:0] integ_q    = '0;

  drive_t drive_due[$];   // drive results still owed by the block

  int sender_idle_pct = 0;
  int rx_stall_pct    = 0;
  int quiet_cycles    = 0;

  // run statistics
  int n_fail        = 0;
  int n_items       = 0;
  int n_results     = 0;
  int n_sat         = 0;
  int n_neg         = 0;
  int n_cfg         = 0;
  int n_integ_clamp = 0;

  // one filter, integral and pi update for an accepted request
  function automatic drive_t speed_loop_step(input logic [SpeedW-1:0] speed,
                                             input logic [DtW-1:0]    dt);
    longint unsigned acc;
    longint unsigned mag;
    longint          err;
    longint          prod;
    longint          delta;
    longint          sum;
    longint          u;
    drive_t          res;
    // two-tap low pass, exact in q8.32, rounded half up to q8.16
    acc = 64'(CoefA) * 64'(filt_q) + ((64'(CoefB) * (64'(speed) + 64'(prev_q))) << 8);
    acc = (acc + 64'h8000) >> 16;
    if (acc > 64'hFF_FFFF) acc = 64'hFF_FFFF;
    filt_q = FiltW'(acc);
    prev_q = speed;
    // error in q.16
    err = longint'({setpoint_q, 8'd0}) - longint'(filt_q);
    // error times time step in q.36, rounded half away from zero to q.16
    prod  = err * longint'(dt);
    mag   = (prod < 0) ? -prod : prod;
    delta = longint'((mag + 64'd524288) >> 20);
    if (prod < 0) delta = -delta;
    sum = longint'(integ_q) + delta;
    if (sum > IntegMax) begin
      sum = IntegMax;
      n_integ_clamp++;
    end else if (sum < IntegMin) begin
      sum = IntegMin;
      n_integ_clamp++;
    end
    integ_q = IntegW'(sum);
    // pi sum in q.24, magnitude truncated to an integer
    u   = longint'(p_gain_q) * err + longint'(i_gain_q) * longint'(integ_q);
    mag = (u < 0) ? -u : u;
    mag = mag >> 24;
    res.neg   = (u < 0);
    res.sat   = (mag > 255);
    res.level = res.sat ? '1 : DriveW'(mag);
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int exp_v, input int got_v);
    n_fail++;
    if (n_fail <= MaxPrints)
      $display("mismatch at result %0d: %s expected %0d got %0d",
               n_results, what, exp_v, got_v);
  endtask

  // --------------------------------------------------------------------------
  // clock, watchdog
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // any handshake on any channel counts as progress
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= QuietLimit);
    $display("watchdog: no handshake for %0d cycles, %0d results still owed",
             QuietLimit, drive_due.size());
    $display("FAIL");
    $finish;
  end

  // --------------------------------------------------------------------------
  // result side: random back-pressure and compare against the oldest owed drive
  // --------------------------------------------------------------------------
  initial begin
    drive_t want;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_ch.valid && out_ch.ready) begin
        n_results++;
        if (out_ch.drive_saturated) n_sat++;
        if (out_ch.demand_negative) n_neg++;
        if (drive_due.size() == 0) begin
          report_mismatch("unrequested result, drive_level", -1,
                          int'(out_ch.drive_level));
        end else begin
          want = drive_due.pop_front();
          if (out_ch.drive_level !== want.level)
            report_mismatch("drive_level", int'(want.level), int'(out_ch.drive_level));
          if (out_ch.drive_saturated !== want.sat)
            report_mismatch("drive_saturated", int'(want.sat),
                            int'(out_ch.drive_saturated));
          if (out_ch.demand_negative !== want.neg)
            report_mismatch("demand_negative", int'(want.neg),
                            int'(out_ch.demand_negative));
        end
      end
      // ready for the next edge; one assignment per step
      out_ch.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // request side
  // --------------------------------------------------------------------------

  // one speed request; valid stays up across back-to-back requests
  task automatic send_speed(input logic [SpeedW-1:0] speed, input logic [DtW-1:0] dt,
                            input bit known, input drive_t known_drive);
    drive_t pred;
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid          <= 1'b1;
    in_ch.measured_speed <= speed;
    in_ch.time_step      <= dt;
    do @(posedge clk_i); while (!in_ch.ready);
    // model state advances on every accepted request, typed rows included
    pred = speed_loop_step(speed, dt);
    drive_due.push_back(known ? known_drive : pred);
    n_items++;
  endtask

  // drop valid and wait for every owed result
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (drive_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk_i); while (!cfg_ch.ready);
    case (idx)
      REG_SETPOINT: setpoint_q = value;
      REG_P_GAIN:   p_gain_q   = value;
      REG_I_GAIN:   i_gain_q   = value;
      default: ;    // unknown index, the block must ignore it
    endcase
    n_cfg++;
  endtask

  // all three registers, then a write to an unused index that must not land
  task automatic program_regs(input logic [GainW-1:0] sp, input logic [GainW-1:0] pg,
                              input logic [GainW-1:0] ig);
    write_reg(REG_SETPOINT, sp);
    write_reg(REG_P_GAIN, pg);
    write_reg(REG_I_GAIN, ig);
    write_reg(CfgIdxW'($urandom_range(FirstUnusedIdx, 255)), CfgDataW'($urandom));
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic set_idling(input idle_mode_e mode);
    sender_idle_pct = (mode == IDLE_SENDER) ? 64 : (mode == IDLE_BOTH) ? 8 : 0;
    rx_stall_pct    = (mode == IDLE_RECEIVER) ? 64 : (mode == IDLE_BOTH) ? 8 : 0;
  endtask

  // bursts of tracking, pinned and noisy speed samples
  task automatic run_bursts(input int n_target, input bit pinned_only);
    int          sent;
    int          len;
    int          s;
    bit          hi;
    stim_style_e style;
    logic [SpeedW-1:0] speed;
    logic [DtW-1:0]    dt;
    sent = 0;
    while (sent < n_target) begin
      s = $urandom_range(0, 99);
      style = pinned_only ? STIM_EXTREME :
              (s < 50) ? STIM_TRACK : (s < 75) ? STIM_EXTREME : STIM_NOISE;
      case (style)
        STIM_TRACK:   len = $urandom_range(8, 40);
        STIM_EXTREME: len = $urandom_range(20, 150);
        default:      len = $urandom_range(4, 20);
      endcase
      // pinned bursts mostly push away from the setpoint so the integral winds up
      hi = ($urandom_range(0, 99) < 80) ? (setpoint_q < 16'h8000)
                                        : 1'($urandom_range(0, 1));
      for (int k = 0; k < len && sent < n_target; k++) begin
        case (style)
          STIM_TRACK: begin
            s = int'(setpoint_q) + int'($urandom_range(0, 2048)) - 1024;
            if (s < 0) s = 0;
            if (s > 65535) s = 65535;
            speed = SpeedW'(s);
            dt    = ($urandom_range(0, 9) == 0) ? '0 : DtW'($urandom_range(1, 20'h08000));
          end
          STIM_EXTREME: begin
            speed = hi ? SpeedW'(16'hFFFF - $urandom_range(0, 3)) : SpeedW'($urandom_range(0, 3));
            dt    = DtW'($urandom_range(20'hC0000, 20'hFFFFF));
          end
          default: begin
            speed = SpeedW'($urandom);
            dt    = ($urandom_range(0, 7) == 0) ? '0 : DtW'($urandom);
          end
        endcase
        send_speed(speed, dt, 1'b0, '0);
        sent++;
      end
    end
  endtask

  // hand-picked requests under reset settings; the first rows are plain to
  // read: zero speed against a 100.0 setpoint with a gain of 4 gives a demand
  // of 400, which clips
  speed_vec_t speed_vecs [22] = '{
    '{16'h0000, 20'h00000, 1'b1, {8'd255, 1'b1, 1'b0}},  // after reset
    '{16'h0000, 20'h00000, 1'b1, {8'd255, 1'b1, 1'b0}},  // zero time step, integral held
    '{16'h0000, 20'hFFFFF, 1'b1, {8'd255, 1'b1, 1'b0}},  // longest step, integral grows
    '{16'hFFFF, 20'h00000, 1'b0, '0},                    // full speed enters the taps
    '{16'hFFFF, 20'h00001, 1'b0, '0},
    '{16'hFFFF, 20'hFFFFF, 1'b0, '0},
    '{16'hFFFF, 20'h80000, 1'b0, '0},                    // filter climbs past the setpoint
    '{16'hFFFF, 20'h80000, 1'b0, '0},
    '{16'hFFFF, 20'h80000, 1'b0, '0},
    '{16'hFFFF, 20'h40000, 1'b0, '0},
    '{16'hFFFF, 20'h40000, 1'b0, '0},
    '{16'h6400, 20'h10000, 1'b0, '0},                    // speed at the setpoint
    '{16'h6400, 20'h10000, 1'b0, '0},
    '{16'h6400, 20'h00000, 1'b0, '0},
    '{16'hAAAA, 20'h55555, 1'b0, '0},                    // alternating bit patterns
    '{16'h5555, 20'hAAAAA, 1'b0, '0},
    '{16'h0001, 20'h00001, 1'b0, '0},                    // smallest nonzero values
    '{16'h8000, 20'hFFFFF, 1'b0, '0},
    '{16'h0000, 20'hFFFFF, 1'b0, '0},
    '{16'h0000, 20'hFFFFF, 1'b0, '0},
    '{16'h7FFF, 20'h7FFFF, 1'b0, '0},
    '{16'h0000, 20'h00000, 1'b0, '0}
  };

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    logic [GainW-1:0] sp;
    logic [GainW-1:0] pg;
    logic [GainW-1:0] ig;

    // all block inputs known from time zero
    rst_ni               = 1'b0;
    in_ch.valid          = 1'b0;
    in_ch.measured_speed = '0;
    in_ch.time_step      = '0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.index         = REG_SETPOINT;
    cfg_ch.data          = '0;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table, reset register values, no idling
    set_idling(IDLE_NONE);
    foreach (speed_vecs[i])
      send_speed(speed_vecs[i].speed, speed_vecs[i].dt, speed_vecs[i].known,
                 speed_vecs[i].drive);
    drain_results();

    // random phases: each one reprograms the registers while the block is idle
    for (int ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        0: begin sp = 16'hFFFF; pg = 16'h0040; ig = 16'h0010; end  // positive wind-up
        1: begin sp = 16'h0000; pg = 16'hFFFF; ig = 16'h0000; end
        2: begin sp = 16'h0000; pg = 16'h0000; ig = 16'hFFFF; end
        3: begin sp = 16'h0000; pg = 16'h0020; ig = 16'h0008; end  // negative wind-up
        4: begin sp = SetpointRst; pg = PGainRst; ig = IGainRst; end
        5: begin sp = GainW'($urandom); pg = '0; ig = '0; end      // zero demand
        6: begin sp = 16'hFFFF; pg = 16'hFFFF; ig = 16'hFFFF; end
        default: begin
          // small gains keep the drive mostly below the clip level
          sp = GainW'($urandom);
          pg = (ph % 3 == 0) ? GainW'($urandom) : GainW'($urandom_range(0, 16'h0200));
          ig = (ph % 3 == 0) ? GainW'($urandom) : GainW'($urandom_range(0, 16'h0040));
        end
      endcase
      program_regs(sp, pg, ig);
      set_idling(idle_mode_e'(ph % 4));
      if (ph == 0 || ph == 3) run_bursts(SatPhaseItems, 1'b1);
      else run_bursts(PhaseItems, 1'b0);
      drain_results();
    end

    // settle with the receiver always ready so a stray extra result shows up
    set_idling(IDLE_NONE);
    drain_results();
    repeat (DrainCycles) @(posedge clk_i);

    $display("covered %0d speed requests and %0d drive results over %0d register writes",
             n_items, n_results, n_cfg);
    $display("saw %0d clipped drives, %0d negative demands, %0d integral clamps, %0d mismatches",
             n_sat, n_neg, n_integ_clamp, n_fail);
    if (n_fail == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/fpsc_pkg.sv
rtl/core/fpsc_if.sv
rtl/core/fpsc_mac.sv
rtl/core/fpsc_ctrl.sv
rtl/core/filtered_pi_speed_controller_top.sv
test/tb_filtered_pi_speed_controller_top.sv
